// ===== hdl/lgs_pkg.sv =====
// Shared types, constants and the B3/S23 rule for the life generation stencil.
// Used by every module of the block; it depends on nothing else.
package lgs_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned IDX_W      = 5;

  // One grid column as seen by the stencil: the row above, the middle row and the row below.
  typedef struct packed {
    logic two;
    logic one;
    logic now;
  } column_t;

  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic             alive;
  } result_t;

  function automatic logic [3:0] column_sum(column_t c);
    logic [3:0] s;
    s = 4'(c.two) + 4'(c.one) + 4'(c.now);
    return s;
  endfunction

  // The window count includes the cell itself, so survival means a count of three or four.
  function automatic logic next_state(column_t lft, column_t mid, column_t rgt, logic self);
    logic [3:0] total;
    total = column_sum(lft) + column_sum(mid) + column_sum(rgt);
    return (total == 4'd3) || (self && (total == 4'd4));
  endfunction

endpackage

// ===== hdl/lgs_cell.sv =====
// One cell of the column chain: holds the three row bits of one grid column.
// Depends on lgs_pkg for the column type.
module lgs_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             shift,
  input  lgs_pkg::column_t din,
  output lgs_pkg::column_t dout
);
  import lgs_pkg::*;

  column_t col_r;
  column_t col_nxt;

  always_comb begin
    col_nxt = col_r;
    if (clr) begin
      col_nxt = '0;
    end else if (shift) begin
      col_nxt = din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign dout = col_r;

endmodule

// ===== hdl/lgs_res_fifo.sv =====
// Small result queue that takes up to two results per cycle and hands out one.
// Depends on lgs_pkg for the result type and the queue depth.
module lgs_res_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push0,
  input  logic             push1,
  input  lgs_pkg::result_t din0,
  input  lgs_pkg::result_t din1,
  output logic             room,
  output logic             dout_valid,
  input  logic             dout_ready,
  output lgs_pkg::result_t dout
);
  import lgs_pkg::*;

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]     count_r, count_nxt;
  logic                 pop;
  logic [FIFO_AW-1:0]   wr_ptr_p1;

  assign pop        = dout_valid && dout_ready;
  assign dout_valid = (count_r != '0);
  assign dout       = mem[rd_ptr_r];
  assign room       = (count_r < (FIFO_AW+1)'(FIFO_DEPTH - 1));
  assign wr_ptr_p1  = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push0) + FIFO_AW'(push1);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + (FIFO_AW+1)'(push0) + (FIFO_AW+1)'(push1) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr_r] <= din0;
    end
    if (push1) begin
      mem[wr_ptr_p1] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/life_generation_stencil.sv =====
// Top level of the life generation stencil: column chain, step control and result queue.
// Depends on lgs_pkg, lgs_cell and lgs_res_fifo.
//
// The block takes one grid cell per cycle in raster order and returns the next B3/S23
// generation in raster order, one row behind the input, with cells outside the grid dead.
// A chain of MAX_SIZE column cells moves one place per accepted cell, so a request is
// taken every cycle while a row streams in and results are taken; the end of a row yields
// two results and the start of the next row none, which the four-entry result queue
// absorbs. After the last cell of a frame the input stalls while the chain runs on with
// one dead cell per grid column to flush the last row; the chain is cleared on the last
// of those steps and the next frame may then start. A write to grid_size (clamped to
// 3..MAX_SIZE) restarts the frame.
module life_generation_stencil #(
  parameter int unsigned MAX_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,    // grid_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [0] cell_alive
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [0] next_alive, [5:1] out_row, [10:6] out_col
  output logic        out_tlast     // frame_last
);
  import lgs_pkg::*;

  localparam int unsigned CW       = $clog2(MAX_SIZE);
  localparam int unsigned SIZE_RST = (MAX_SIZE < 32) ? MAX_SIZE : 32;

  column_t          cell_q [MAX_SIZE];
  column_t          head;
  column_t          entry;
  column_t          prev1;
  column_t          prev2;
  logic [CW-1:0]    size_m1_r, size_m1_nxt;
  logic [CW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic             flush_r, flush_nxt;
  logic [CW-1:0]    head_idx;
  logic [CW-1:0]    col_m1;
  logic [CW-1:0]    emit_row;
  logic [6:0]       size_req;
  logic [6:0]       size_clamp;
  logic             room;
  logic             step;
  logic             at_row_end;
  logic             at_last_row;
  logic             emit_a;
  logic             emit_b;
  logic             chain_clr;
  logic             in_bit;
  result_t          res_a;
  result_t          res_b;
  result_t          res_out;

  assign head_idx = CW'(MAX_SIZE - 1) - size_m1_r;
  assign head     = cell_q[head_idx];
  assign prev1    = cell_q[MAX_SIZE-1];
  assign prev2    = (col_r >= CW'(2)) ? cell_q[MAX_SIZE-2] : '0;
  assign in_bit   = flush_r ? 1'b0 : in_tdata[0];

  always_comb begin
    entry     = '0;
    entry.two = head.one;
    entry.one = head.now;
    entry.now = in_bit;
  end

  assign in_tready   = room && !flush_r;
  assign step        = room && (flush_r || in_tvalid);
  assign at_row_end  = (col_r == size_m1_r);
  assign at_last_row = (row_r == size_m1_r);
  assign col_m1      = col_r - 1'b1;
  assign emit_row    = flush_r ? row_r : (row_r - 1'b1);

  assign emit_a = step && (flush_r || (row_r != '0)) && (col_r != '0);
  assign emit_b = step && (flush_r || (row_r != '0)) && at_row_end;

  always_comb begin
    res_a       = '0;
    res_a.alive = next_state(prev2, prev1, entry, prev1.one);
    res_a.row   = IDX_W'(emit_row);
    res_a.col   = IDX_W'(col_m1);
    res_a.last  = 1'b0;
    res_b       = '0;
    res_b.alive = next_state(prev1, entry, column_t'('0), entry.one);
    res_b.row   = IDX_W'(emit_row);
    res_b.col   = IDX_W'(size_m1_r);
    res_b.last  = flush_r;
  end

  always_comb begin
    size_req   = {1'b0, cfg_wdata};
    size_clamp = size_req;
    if (size_req < 7'd3) begin
      size_clamp = 7'd3;
    end else if (size_req > 7'(MAX_SIZE)) begin
      size_clamp = 7'(MAX_SIZE);
    end
  end

  always_comb begin
    size_m1_nxt = size_m1_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    flush_nxt   = flush_r;
    chain_clr   = 1'b0;
    if (cfg_we) begin
      size_m1_nxt = CW'(size_clamp - 7'd1);
      row_nxt     = '0;
      col_nxt     = '0;
      flush_nxt   = 1'b0;
      chain_clr   = 1'b1;
    end else if (step) begin
      if (flush_r) begin
        if (at_row_end) begin
          flush_nxt = 1'b0;
          row_nxt   = '0;
          col_nxt   = '0;
          chain_clr = 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end else if (at_row_end && at_last_row) begin
        flush_nxt = 1'b1;
        col_nxt   = '0;
      end else if (at_row_end) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_m1_r <= CW'(SIZE_RST - 1);
      row_r     <= '0;
      col_r     <= '0;
      flush_r   <= 1'b0;
    end else begin
      size_m1_r <= size_m1_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      flush_r   <= flush_nxt;
    end
  end

  for (genvar k = 0; k < MAX_SIZE; k++) begin : g_chain
    column_t din;
    if (k == MAX_SIZE - 1) begin : g_tail
      assign din = entry;
    end else begin : g_body
      assign din = cell_q[k+1];
    end
    lgs_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .clr   (chain_clr),
      .shift (step),
      .din   (din),
      .dout  (cell_q[k])
    );
  end

  lgs_res_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push0      (emit_a),
    .push1      (emit_b),
    .din0       (res_a),
    .din1       (res_b),
    .room       (room),
    .dout_valid (out_tvalid),
    .dout_ready (out_tready),
    .dout       (res_out)
  );

  assign out_tdata = {5'b0, res_out.col, res_out.row, res_out.alive};
  assign out_tlast = res_out.last;

endmodule
